/* rtl/core/bcbb_pkg.sv */
// Shared constants and types of the border crop bounding box unit.
`default_nettype none

package bcbb_pkg;

  // Fixed field widths of the streams and the register port.
  localparam int PIXEL_W   = 32;
  localparam int COORD_W   = 13;
  localparam int CFG_W     = 13;
  localparam int COUNT_W   = 3;
  localparam int MARGIN_W  = 7;
  localparam int REG_IDX_W = 3;
  localparam int RESULT_W  = 4 * COORD_W + 1;
  localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

  // Frame size limit and the number of 8-bit components that may be compared.
  localparam int MAX_DIMENSION_DEF = 4096;
  localparam int MAX_COMPONENTS    = 4;
  localparam int PIXEL_BYTES       = PIXEL_W / 8;
  localparam int COMP_LIMIT = (MAX_COMPONENTS < PIXEL_BYTES) ? MAX_COMPONENTS : PIXEL_BYTES;

  // Register reset values.
  localparam logic [CFG_W-1:0]    FRAME_WIDTH_RST  = CFG_W'(640);
  localparam logic [CFG_W-1:0]    FRAME_HEIGHT_RST = CFG_W'(480);
  localparam logic [COUNT_W-1:0]  COMP_COUNT_RST   = COUNT_W'(3);
  localparam logic [MARGIN_W-1:0] MARGIN_RST       = '0;

  // Register indexes on the write port.
  typedef enum logic [REG_IDX_W-1:0] {
    REG_FRAME_WIDTH     = 3'd0,
    REG_FRAME_HEIGHT    = 3'd1,
    REG_COMPONENT_COUNT = 3'd2,
    REG_X_MARGIN        = 3'd3,
    REG_Y_MARGIN        = 3'd4
  } reg_index_t;

  // Current register contents.
  typedef struct packed {
    logic [CFG_W-1:0]    frame_width;
    logic [CFG_W-1:0]    frame_height;
    logic [COUNT_W-1:0]  component_count;
    logic [MARGIN_W-1:0] x_margin;
    logic [MARGIN_W-1:0] y_margin;
  } cfg_t;

  // One crop result, content_found uppermost so that the pack matches tdata.
  typedef struct packed {
    logic                      content_found;
    logic        [COORD_W-1:0] crop_height;
    logic        [COORD_W-1:0] crop_width;
    logic signed [COORD_W-1:0] crop_top;
    logic signed [COORD_W-1:0] crop_left;
  } result_t;

endpackage

`default_nettype wire

/* rtl/core/bcbb_tracker.sv */
// Frame position counters, background reference and content extent tracking.
`default_nettype none

module bcbb_tracker
  import bcbb_pkg::*;
#(
  parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                advance,
  input  wire logic [PIXEL_W-1:0]  pixel,
  input  wire cfg_t                cfg,
  output logic                     frame_end,
  output result_t                  result
);

  localparam int DIM_W = $clog2(MAX_DIMENSION);
  localparam int CMP_W = (DIM_W + 1 > CFG_W) ? DIM_W + 1 : CFG_W;
  localparam logic [CMP_W-1:0] DIM_MAX = CMP_W'(MAX_DIMENSION);
  localparam logic [CMP_W-1:0] DIM_ONE = CMP_W'(1);

  logic [DIM_W-1:0]   column_counter, row_counter;
  logic [DIM_W-1:0]   min_column, max_column, min_row, max_row;
  logic               any_content;
  logic [PIXEL_W-1:0] reference_pixel;

  logic [CMP_W-1:0]   width_eff, height_eff, fw_ext, fh_ext;
  logic               last_col, last_row, first_pixel, differs;
  logic [COUNT_W-1:0] comp_eff;
  logic [PIXEL_W-1:0] cmp_mask, ref_eff;
  logic [DIM_W-1:0]   min_col_upd, max_col_upd, min_row_upd, max_row_upd;
  logic               any_upd;
  logic [COORD_W-1:0] span_col, span_row;

  // Clamp the frame size and find the end of the row and of the frame.
  always_comb begin
    fw_ext = CMP_W'(cfg.frame_width);
    fh_ext = CMP_W'(cfg.frame_height);
    if (fw_ext == '0) begin
      width_eff = DIM_ONE;
    end else if (fw_ext > DIM_MAX) begin
      width_eff = DIM_MAX;
    end else begin
      width_eff = fw_ext;
    end
    if (fh_ext == '0) begin
      height_eff = DIM_ONE;
    end else if (fh_ext > DIM_MAX) begin
      height_eff = DIM_MAX;
    end else begin
      height_eff = fh_ext;
    end
    last_col  = CMP_W'(column_counter) >= (width_eff - DIM_ONE);
    last_row  = CMP_W'(row_counter) >= (height_eff - DIM_ONE);
    frame_end = last_col && last_row;
  end

  // Byte mask of the compared components, low bytes first.
  always_comb begin
    if (cfg.component_count == '0) begin
      comp_eff = COUNT_W'(1);
    end else if (cfg.component_count > COUNT_W'(COMP_LIMIT)) begin
      comp_eff = COUNT_W'(COMP_LIMIT);
    end else begin
      comp_eff = cfg.component_count;
    end
    for (int k = 0; k < PIXEL_BYTES; k++) begin
      cmp_mask[8*k +: 8] = (COUNT_W'(k) < comp_eff) ? 8'hFF : 8'h00;
    end
  end

  // Compare with the background; the first pixel of a frame is its own reference.
  always_comb begin
    first_pixel = (column_counter == '0) && (row_counter == '0);
    ref_eff     = first_pixel ? pixel : reference_pixel;
    differs     = ((pixel ^ ref_eff) & cmp_mask) != '0;
  end

  // Extent including the current pixel.
  always_comb begin
    min_col_upd = min_column;
    max_col_upd = max_column;
    min_row_upd = min_row;
    max_row_upd = max_row;
    any_upd     = any_content;
    if (differs) begin
      any_upd = 1'b1;
      if (!any_content) begin
        min_col_upd = column_counter;
        max_col_upd = column_counter;
        min_row_upd = row_counter;
        max_row_upd = row_counter;
      end else begin
        if (column_counter < min_column) min_col_upd = column_counter;
        if (column_counter > max_column) max_col_upd = column_counter;
        if (row_counter < min_row) min_row_upd = row_counter;
        if (row_counter > max_row) max_row_upd = row_counter;
      end
    end
  end

  // Crop window widened by the margins, all zero for an empty frame.
  always_comb begin
    span_col = COORD_W'(max_col_upd) - COORD_W'(min_col_upd) + COORD_W'(1);
    span_row = COORD_W'(max_row_upd) - COORD_W'(min_row_upd) + COORD_W'(1);
    result   = '0;
    if (any_upd) begin
      result.crop_left     = COORD_W'(min_col_upd) - COORD_W'(cfg.x_margin);
      result.crop_top      = COORD_W'(min_row_upd) - COORD_W'(cfg.y_margin);
      result.crop_width    = span_col + COORD_W'({cfg.x_margin, 1'b0});
      result.crop_height   = span_row + COORD_W'({cfg.y_margin, 1'b0});
      result.content_found = 1'b1;
    end
  end

  // Tracking state: cleared at the end of each frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_counter <= '0;
      row_counter    <= '0;
      min_column     <= '1;
      max_column     <= '0;
      min_row        <= '1;
      max_row        <= '0;
      any_content    <= 1'b0;
    end else if (advance) begin
      if (frame_end) begin
        column_counter <= '0;
        row_counter    <= '0;
        min_column     <= '1;
        max_column     <= '0;
        min_row        <= '1;
        max_row        <= '0;
        any_content    <= 1'b0;
      end else begin
        min_column  <= min_col_upd;
        max_column  <= max_col_upd;
        min_row     <= min_row_upd;
        max_row     <= max_row_upd;
        any_content <= any_upd;
        if (last_col) begin
          column_counter <= '0;
          row_counter    <= row_counter + DIM_W'(1);
        end else begin
          column_counter <= column_counter + DIM_W'(1);
        end
      end
    end
  end

  // Background reference, taken from the first pixel of each frame.
  always_ff @(posedge clk) begin
    if (advance && first_pixel) begin
      reference_pixel <= pixel;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/border_crop_bounding_box_unit.sv */
// Top level of the border crop bounding box unit.
//
//  Channel | Signals                       | Direction | Content
//  --------+-------------------------------+-----------+--------------------------------
//  s_      | s_tvalid s_tready s_tdata[31:0] | in      | one pixel per transaction
//  m_      | m_tvalid m_tready m_tdata[55:0] | out     | one crop result per frame
//  cfg_    | cfg_wen cfg_index cfg_wdata     | in      | register writes, no read-back
//
// One pixel is taken per clock. A pixel waits in the input register and is counted and
// compared when it moves on; the result of a frame is loaded into the output register
// as its last pixel moves on. Only a result still waiting in the output register holds
// the input back, and only when the held pixel ends a frame. Synchronous reset loads
// the register reset values and clears the valid flags, position counters and extent.
`default_nettype none

module border_crop_bounding_box_unit
  import bcbb_pkg::*;
#(
  parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // Pixel stream.
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [PIXEL_W-1:0]     s_tdata,   // pixel_value[31:0]
  // Result stream.
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_TDATA_W-1:0]      m_tdata,   // crop_left[12:0], crop_top[25:13],
                                                 // crop_width[38:26], crop_height[51:39],
                                                 // content_found[52], zero[55:53]
  // Register write port.
  input  wire logic                   cfg_wen,
  input  wire logic [REG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_wdata
);

  cfg_t               cfg;
  logic               in_valid;
  logic [PIXEL_W-1:0] in_pixel;
  logic               frame_end, out_free, advance;
  result_t            result;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width     <= FRAME_WIDTH_RST;
      cfg.frame_height    <= FRAME_HEIGHT_RST;
      cfg.component_count <= COMP_COUNT_RST;
      cfg.x_margin        <= MARGIN_RST;
      cfg.y_margin        <= MARGIN_RST;
    end else if (cfg_wen) begin
      unique case (reg_index_t'(cfg_index))
        REG_FRAME_WIDTH:     cfg.frame_width     <= cfg_wdata;
        REG_FRAME_HEIGHT:    cfg.frame_height    <= cfg_wdata;
        REG_COMPONENT_COUNT: cfg.component_count <= cfg_wdata[COUNT_W-1:0];
        REG_X_MARGIN:        cfg.x_margin        <= cfg_wdata[MARGIN_W-1:0];
        REG_Y_MARGIN:        cfg.y_margin        <= cfg_wdata[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // The held pixel moves on unless it ends a frame and the result slot is taken.
  always_comb begin
    out_free = !m_tvalid || m_tready;
    advance  = in_valid && (!frame_end || out_free);
    s_tready = !in_valid || advance;
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_pixel <= s_tdata;
    end
  end

  bcbb_tracker #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_tracker (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .pixel     (in_pixel),
    .cfg       (cfg),
    .frame_end (frame_end),
    .result    (result)
  );

  // Output register: loaded by the last pixel of a frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && frame_end) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && frame_end) begin
      m_tdata <= OUT_TDATA_W'(result);
    end
  end

endmodule

`default_nettype wire

/* rtl/core/bcbb_checker.sv */
// Port-level checks of the border crop bounding box unit and their binding.
`default_nettype none

module bcbb_checker
  import bcbb_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   s_tready,
  input wire logic                   m_tvalid,
  input wire logic                   m_tready,
  input wire logic [OUT_TDATA_W-1:0] m_tdata
);

  // A stalled result keeps its contents.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // No result is pending straight after reset.
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // With the result slot empty the pixel input never stalls.
  assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with no result pending");

  // A frame without content reports an all-zero window.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[4*COORD_W] |-> m_tdata[4*COORD_W-1:0] == '0)
    else $error("empty frame with non-zero window");

endmodule

bind border_crop_bounding_box_unit bcbb_checker u_bcbb_checker (.*);

`default_nettype wire
